### rtl/interval_set_union_subtract_macros.svh
// Assertion macros for the interval set block.
// Used by the top level; has no dependencies of its own.
`ifndef INTERVAL_SET_UNION_SUBTRACT_MACROS_SVH
`define INTERVAL_SET_UNION_SUBTRACT_MACROS_SVH
`ifndef SYNTHESIS
`define ISU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ISU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ISU_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ISU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/isu_pkg.sv
// Shared constants and types of the interval set block.
// No dependencies; used by isu_step and the top level.
`default_nettype none
package isu_pkg;
   localparam int DEFAULT_MAX_ENTRIES = 32;
   localparam int DEFAULT_VALUE_BITS  = 8;

   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_ORDER = 2'd2;
   localparam logic [1:0] STATUS_INDEX = 2'd3;

   typedef struct packed {
      logic emit1;
      logic emit2;
      logic place;
      logic merge;
   } step_ctl_type;
endpackage
`default_nettype wire

### rtl/isu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module isu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### rtl/isu_step.sv
// Per-entry decision of the streaming rebuild: what to write for one stored range.
// Depends on isu_pkg.
`default_nettype none
module isu_step #(
   parameter int VALUE_BITS = isu_pkg::DEFAULT_VALUE_BITS
) (
   input  wire logic                  is_remove,
   input  wire logic                  placed,
   input  wire logic                  merging,
   input  wire logic [VALUE_BITS-1:0] ent_lo,
   input  wire logic [VALUE_BITS-1:0] ent_hi,
   input  wire logic [VALUE_BITS-1:0] req_lo,
   input  wire logic [VALUE_BITS-1:0] req_hi,
   input  wire logic [VALUE_BITS-1:0] acc_lo,
   input  wire logic [VALUE_BITS-1:0] acc_hi,
   output isu_pkg::step_ctl_type      ctl,
   output logic      [VALUE_BITS-1:0] w1_lo,
   output logic      [VALUE_BITS-1:0] w1_hi,
   output logic      [VALUE_BITS-1:0] w2_lo,
   output logic      [VALUE_BITS-1:0] w2_hi,
   output logic      [VALUE_BITS-1:0] nacc_lo,
   output logic      [VALUE_BITS-1:0] nacc_hi
);
   logic ov;
   logic cut_lo;
   logic cut_hi;

   always_comb begin
      ov      = (ent_hi >= req_lo) && (ent_lo <= req_hi);
      cut_lo  = ent_lo < req_lo;
      cut_hi  = ent_hi > req_hi;
      ctl     = '0;
      w1_lo   = ent_lo;
      w1_hi   = ent_hi;
      w2_lo   = ent_lo;
      w2_hi   = ent_hi;
      nacc_lo = acc_lo;
      nacc_hi = acc_hi;
      if (is_remove) begin
         // An overlapped entry keeps only the parts outside the range.
         priority if (!ov) begin
            ctl.emit1 = 1'b1;
         end else if (cut_lo) begin
            ctl.emit1 = 1'b1;
            w1_hi     = req_lo - VALUE_BITS'(1);
            if (cut_hi) begin
               ctl.emit2 = 1'b1;
               w2_lo     = req_hi + VALUE_BITS'(1);
            end
         end else if (cut_hi) begin
            ctl.emit1 = 1'b1;
            w1_lo     = req_hi + VALUE_BITS'(1);
         end else begin
            // A fully covered entry is dropped.
            ctl.emit1 = 1'b0;
         end
      end else begin
         priority if (placed) begin
            ctl.emit1 = 1'b1;
         end else if (ov) begin
            ctl.merge = 1'b1;
            nacc_lo   = (ent_lo < acc_lo) ? ent_lo : acc_lo;
            nacc_hi   = (ent_hi > acc_hi) ? ent_hi : acc_hi;
         end else if (merging || (ent_lo > req_lo)) begin
            // The new or merged range goes in just ahead of this entry.
            ctl.emit1 = 1'b1;
            ctl.emit2 = 1'b1;
            ctl.place = 1'b1;
            w1_lo     = acc_lo;
            w1_hi     = acc_hi;
         end else begin
            ctl.emit1 = 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

### rtl/interval_set_union_subtract.sv
// Top level of the sorted disjoint interval set: control sequencer and table RAM.
// Depends on isu_pkg, isu_ram, isu_step and interval_set_union_subtract_macros.svh.
//
//   channel   ports                                    transfer
//   request   start, busy, req_*                       start high while busy low
//   response  rsp_strobe, rsp_*                        every cycle rsp_strobe is high
//
// A read passes through S_RDATA to the response strobe; a read beyond the count goes
// straight to S_RESP. An add or remove rebuilds the table by streaming it through the
// single RAM read port: each stored entry passes through S_FETCH and S_PROC, and also
// through S_EMIT2 when it yields two outputs; S_TAIL and S_RESP then follow.
// A range with start above end, or an unused function code, goes straight to S_RESP.
// The RAM holds two banks; a rebuild writes the idle bank and flips the bank only on
// success, so a refused request leaves the table untouched.
// Reset is synchronous and clears the count and sequencer; the RAM is not cleared.
// The receiver cannot stall; busy stays high from the transfer until the strobe.
`default_nettype none
`include "interval_set_union_subtract_macros.svh"
module interval_set_union_subtract #(
   parameter int MAX_ENTRIES = isu_pkg::DEFAULT_MAX_ENTRIES,
   parameter int VALUE_BITS  = isu_pkg::DEFAULT_VALUE_BITS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_func,
   input  wire logic [7:0] req_range_start,
   input  wire logic [7:0] req_range_end,
   input  wire logic [4:0] req_read_index,
   output logic            rsp_strobe,
   output logic [1:0]      rsp_status,
   output logic [5:0]      rsp_entry_count,
   output logic [7:0]      rsp_entry_start,
   output logic [7:0]      rsp_entry_end
);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int VB = VALUE_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_PROC  = 3'd2;
   localparam logic [2:0] S_EMIT2 = 3'd3;
   localparam logic [2:0] S_TAIL  = 3'd4;
   localparam logic [2:0] S_RDATA = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

   logic [2:0]    state_ff, state_in;
   logic [1:0]    func_ff, func_in;
   logic [VB-1:0] s_ff, s_in, e_ff, e_in;
   logic [CW-1:0] count_ff, count_in;
   logic          bank_ff, bank_in;
   logic [CW-1:0] i_ff, i_in, n_ff, n_in;
   logic          fail_ff, fail_in;
   logic          placed_ff, placed_in, merging_ff, merging_in;
   logic [VB-1:0] acc_lo_ff, acc_lo_in, acc_hi_ff, acc_hi_in;
   logic [VB-1:0] held_lo_ff, held_lo_in, held_hi_ff, held_hi_in;
   logic [1:0]    status_ff, status_in;
   logic [7:0]    out_lo_ff, out_lo_in, out_hi_ff, out_hi_in;

   logic [31:0]     idx32, count32, rs32, re32, ent_lo32, ent_hi32;
   logic [VB-1:0]   req_s, req_e, ent_lo, ent_hi;
   logic [2*VB-1:0] rd_data;
   logic [AW:0]     rd_addr, wr_addr;
   logic            wr_want, wr_en;
   logic [VB-1:0]   wr_lo, wr_hi;
   logic [CW-1:0]   i_next;

   isu_pkg::step_ctl_type ctl;
   logic [VB-1:0] w1_lo, w1_hi, w2_lo, w2_hi, nacc_lo, nacc_hi;

   // Request values are zero-extended or cut to the table's value width.
   assign rs32     = 32'(req_range_start);
   assign re32     = 32'(req_range_end);
   assign req_s    = rs32[VB-1:0];
   assign req_e    = re32[VB-1:0];
   assign idx32    = 32'(req_read_index);
   assign count32  = 32'(count_ff);
   assign ent_lo   = rd_data[2*VB-1:VB];
   assign ent_hi   = rd_data[VB-1:0];
   assign ent_lo32 = 32'(ent_lo);
   assign ent_hi32 = 32'(ent_hi);
   assign i_next   = i_ff + CW'(1);

   // Each bank spans the full power-of-two address range of an entry index.
   isu_ram #(
      .WIDTH (2 * VB),
      .DEPTH (2 << AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({wr_lo, wr_hi}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   isu_step #(
      .VALUE_BITS (VB)
   ) u_step (
      .is_remove (func_ff == isu_pkg::FUNC_REMOVE),
      .placed    (placed_ff),
      .merging   (merging_ff),
      .ent_lo    (ent_lo),
      .ent_hi    (ent_hi),
      .req_lo    (s_ff),
      .req_hi    (e_ff),
      .acc_lo    (acc_lo_ff),
      .acc_hi    (acc_hi_ff),
      .ctl       (ctl),
      .w1_lo     (w1_lo),
      .w1_hi     (w1_hi),
      .w2_lo     (w2_lo),
      .w2_hi     (w2_hi),
      .nacc_lo   (nacc_lo),
      .nacc_hi   (nacc_hi)
   );

   // A write beyond the last entry is dropped and marks the request as refused.
   assign wr_en   = wr_want && (n_ff != MAX_COUNT);
   assign wr_addr = {~bank_ff, n_ff[AW-1:0]};

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      s_in       = s_ff;
      e_in       = e_ff;
      count_in   = count_ff;
      bank_in    = bank_ff;
      i_in       = i_ff;
      placed_in  = placed_ff;
      merging_in = merging_ff;
      acc_lo_in  = acc_lo_ff;
      acc_hi_in  = acc_hi_ff;
      held_lo_in = held_lo_ff;
      held_hi_in = held_hi_ff;
      status_in  = status_ff;
      out_lo_in  = out_lo_ff;
      out_hi_in  = out_hi_ff;
      rd_addr    = {bank_ff, i_ff[AW-1:0]};
      wr_want    = 1'b0;
      wr_lo      = acc_lo_ff;
      wr_hi      = acc_hi_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in    = req_func;
               s_in       = req_s;
               e_in       = req_e;
               acc_lo_in  = req_s;
               acc_hi_in  = req_e;
               i_in       = '0;
               placed_in  = 1'b0;
               merging_in = 1'b0;
               status_in  = isu_pkg::STATUS_OK;
               out_lo_in  = '0;
               out_hi_in  = '0;
               priority if (req_func == isu_pkg::FUNC_READ) begin
                  rd_addr = {bank_ff, idx32[AW-1:0]};
                  if (idx32 >= count32) begin
                     status_in = isu_pkg::STATUS_INDEX;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_RDATA;
                  end
               end else if ((req_func == isu_pkg::FUNC_ADD) ||
                            (req_func == isu_pkg::FUNC_REMOVE)) begin
                  if (req_s > req_e) begin
                     status_in = isu_pkg::STATUS_ORDER;
                     state_in  = S_RESP;
                  end else if (count_ff == '0) begin
                     state_in = S_TAIL;
                  end else begin
                     state_in = S_FETCH;
                  end
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_FETCH: begin
            state_in = S_PROC;
         end
         S_PROC: begin
            wr_want = ctl.emit1;
            wr_lo   = w1_lo;
            wr_hi   = w1_hi;
            if (ctl.place) begin
               placed_in = 1'b1;
            end
            if (ctl.merge) begin
               merging_in = 1'b1;
               acc_lo_in  = nacc_lo;
               acc_hi_in  = nacc_hi;
            end
            if (ctl.emit2) begin
               held_lo_in = w2_lo;
               held_hi_in = w2_hi;
               state_in   = S_EMIT2;
            end else begin
               i_in     = i_next;
               state_in = (i_next == count_ff) ? S_TAIL : S_FETCH;
            end
         end
         S_EMIT2: begin
            wr_want  = 1'b1;
            wr_lo    = held_lo_ff;
            wr_hi    = held_hi_ff;
            i_in     = i_next;
            state_in = (i_next == count_ff) ? S_TAIL : S_FETCH;
         end
         S_TAIL: begin
            // An add that met no later entry still owes its range at the end.
            wr_want  = (func_ff == isu_pkg::FUNC_ADD) && !placed_ff;
            state_in = S_RESP;
            if (fail_in) begin
               status_in = isu_pkg::STATUS_FULL;
            end else begin
               bank_in  = ~bank_ff;
               count_in = n_in;
            end
         end
         S_RDATA: begin
            out_lo_in = ent_lo32[7:0];
            out_hi_in = ent_hi32[7:0];
            state_in  = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      n_in    = n_ff + CW'(wr_en);
      fail_in = fail_ff || (wr_want && !wr_en);
      if (state_ff == S_IDLE) begin
         n_in    = '0;
         fail_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bank_ff  <= bank_in;
      end
      func_ff    <= func_in;
      s_ff       <= s_in;
      e_ff       <= e_in;
      i_ff       <= i_in;
      n_ff       <= n_in;
      fail_ff    <= fail_in;
      placed_ff  <= placed_in;
      merging_ff <= merging_in;
      acc_lo_ff  <= acc_lo_in;
      acc_hi_ff  <= acc_hi_in;
      held_lo_ff <= held_lo_in;
      held_hi_ff <= held_hi_in;
      status_ff  <= status_in;
      out_lo_ff  <= out_lo_in;
      out_hi_ff  <= out_hi_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = (state_ff == S_RESP);
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count32[5:0];
   assign rsp_entry_start = out_lo_ff;
   assign rsp_entry_end   = out_hi_ff;

   `ISU_ASSERT_SAME(a_wr_in_range, clock, reset, wr_en, n_ff < MAX_COUNT)
   `ISU_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= MAX_COUNT)
   `ISU_ASSERT_NEXT(a_resp_frees, clock, reset, rsp_strobe, !busy)
   `ISU_ASSERT_NEXT(a_start_takes, clock, reset, start && !busy, busy)
endmodule
`default_nettype wire
